### rtl/zts_pkg.sv
// ----------------------------------------------------------------------------
// zts_pkg
// shared types, constants and codes of the zone timing statistics unit
// ----------------------------------------------------------------------------
package zts_pkg;

    // zone store
    localparam int NUM_ZONES  = 8;
    localparam int ZONE_W     = 3;
    localparam int ZONE_IDX_W = $clog2(NUM_ZONES);

    // conversion register
    localparam int              CPU_W     = 10;
    localparam logic [CPU_W-1:0] CPU_RESET = 10'd240;
    localparam int              PADDR_W   = 2;

    // register map
    localparam logic [PADDR_W-1:0] ADDR_CYCLES_PER_US = '0;

    localparam logic [31:0] MIN_UNSET = 32'hFFFF_FFFF;

    // radix-4 divider: two quotient bits a cycle, 32-bit quotient
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ZONE_W-1:0] zone;
        logic [31:0]       now_cycles;
    } cmd_t;

    typedef struct packed {
        logic [31:0] avg_us;
        logic [31:0] min_us;
        logic [31:0] max_us;
        logic [31:0] sample_count;
    } stat_t;

    typedef struct packed {
        logic [31:0] start_stamp;
        logic [31:0] min_elapsed;
        logic [31:0] max_elapsed;
        logic [63:0] total_elapsed;
        logic [31:0] samples;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        start_stamp:   32'd0,
        min_elapsed:   MIN_UNSET,
        max_elapsed:   32'd0,
        total_elapsed: 64'd0,
        samples:       32'd0
    };

    typedef struct packed {
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [31:0] rem_init;
    } div_req_t;

    typedef struct packed {
        logic                  rd_en;
        logic [ZONE_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [ZONE_IDX_W-1:0] wr_addr;
        logic                  clear_all;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_KICK1,
        ST_WAIT1,
        ST_KICK2,
        ST_WAIT2,
        ST_OUT
    } state_t;

endpackage

### rtl/zts_div.sv
// ----------------------------------------------------------------------------
// zts_div
// iterative radix-4 restoring divider, 32-bit quotient in 16 steps
// ----------------------------------------------------------------------------
module zts_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  zts_pkg::div_req_t req,
    output logic              done,
    output logic [31:0]       quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [zts_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]                   rem_reg, rem_next;
    logic [31:0]                   quo_reg, quo_next;
    logic [31:0]                   dvs_reg, dvs_next;

    logic [32:0] r_a, r_b;
    logic        ge_a, ge_b;
    logic [31:0] rem_a, rem_b;
    logic        last_step;

    // two dependent restoring steps
    always_comb
    begin
        r_a   = {rem_reg, quo_reg[31]};
        ge_a  = r_a >= {1'b0, dvs_reg};
        rem_a = ge_a ? 32'(r_a - {1'b0, dvs_reg}) : r_a[31:0];
        r_b   = {rem_a, quo_reg[30]};
        ge_b  = r_b >= {1'b0, dvs_reg};
        rem_b = ge_b ? 32'(r_b - {1'b0, dvs_reg}) : r_b[31:0];
    end

    assign last_step = cnt_reg == zts_pkg::DIV_CNT_W'(zts_pkg::DIV_STEPS - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.rem_init;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_b;
            quo_next = {quo_reg[29:0], ge_a, ge_b};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/zts_stat_mem.sv
// ----------------------------------------------------------------------------
// zts_stat_mem
// per-zone statistics memory, registered read, valid bit per entry
// ----------------------------------------------------------------------------
module zts_stat_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  zts_pkg::mem_ctl_t ctl,
    input  zts_pkg::entry_t   wr_data,
    output zts_pkg::entry_t   rd_data
);

    zts_pkg::entry_t                 mem_array [zts_pkg::NUM_ZONES];
    zts_pkg::entry_t                 rd_q_reg;
    logic [zts_pkg::NUM_ZONES-1:0]   valid_reg, valid_next;
    logic                            rd_valid_reg, rd_valid_next;

    // clear-all drops every valid bit, an invalid entry reads as reset value
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear_all)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[ctl.wr_addr] = 1'b1;
        end
        rd_valid_next = ctl.rd_en ? valid_reg[ctl.rd_addr] : rd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_array[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem_array[ctl.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : zts_pkg::ENTRY_RESET;

endmodule

### rtl/zone_timing_statistics_unit.sv
// ----------------------------------------------------------------------------
// zone_timing_statistics_unit
// per-zone timing monitor: min, max, average and sample count per zone
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  -------------------------------
//  cmd      in         cmd_valid / cmd_ready   zts_pkg::cmd_t  (opcode, zone,
//                                              now_cycles)
//  stat     out        stat_valid / stat_ready zts_pkg::stat_t (avg_us, min_us,
//                                              max_us, sample_count)
//  apb      in         psel / penable / pready cycles_per_us at address 0
//
//  one item at a time: the accept cycle with the memory read, the update and
//    write back, two rounds of the 16-step radix-4 dividers (total / samples
//    and min / cycles, then average / cycles and max / cycles) and a load of
//    the output register; the next item is accepted only after that load
//  reset leaves every zone at its cleared value through the valid bits of
//    the statistics memory; no clearing pass is needed
//  a result waiting in the output register does not block the next item;
//    only the load of the following result waits for stat_ready
//
module zone_timing_statistics_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // item input
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  zts_pkg::cmd_t                 cmd,
    // result output
    output logic                          stat_valid,
    input  logic                          stat_ready,
    output zts_pkg::stat_t                stat,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zts_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    zts_pkg::state_t state_reg, state_next;

    // configuration register
    logic [zts_pkg::CPU_W-1:0] cpu_reg, cpu_next;
    logic                      cfg_wr;
    logic [31:0]               cpu_div;

    // captured item and working entry
    zts_pkg::cmd_t   cmd_reg, cmd_next;
    zts_pkg::entry_t work_reg, work_next;
    logic            zone_ok_reg, zone_ok_next;
    logic            sat_reg, sat_next;
    logic [31:0]     min_q_reg, min_q_next;

    // output register
    zts_pkg::stat_t stat_reg, stat_next;
    logic           stat_valid_reg, stat_valid_next;

    // memory
    zts_pkg::mem_ctl_t mem_ctl;
    zts_pkg::entry_t   mem_rd;
    zts_pkg::entry_t   upd;
    logic [31:0]       elapsed;
    logic              zone_ok;

    // dividers
    logic              div_start;
    zts_pkg::div_req_t req_a, req_b;
    logic              done_a, done_b;
    logic [31:0]       quo_a, quo_b;

    // fsm outputs
    logic accept;
    logic load_out;

    // ------------------------------------------------------------------
    // configuration port, cycles_per_us at address 0
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr == zts_pkg::ADDR_CYCLES_PER_US);
    assign prdata  = {{(32 - zts_pkg::CPU_W){1'b0}}, cpu_reg};
    assign cpu_next = cfg_wr ? pwdata[zts_pkg::CPU_W-1:0] : cpu_reg;

    // zero converts as one, statistics then come out in cycles
    assign cpu_div = (cpu_reg == '0) ? 32'd1 : {{(32 - zts_pkg::CPU_W){1'b0}}, cpu_reg};

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zts_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = zts_pkg::ST_UPDATE;
                end
            end
            zts_pkg::ST_UPDATE: state_next = zts_pkg::ST_KICK1;
            zts_pkg::ST_KICK1:  state_next = zts_pkg::ST_WAIT1;
            zts_pkg::ST_WAIT1:
            begin
                if (done_a)
                begin
                    state_next = zts_pkg::ST_KICK2;
                end
            end
            zts_pkg::ST_KICK2:  state_next = zts_pkg::ST_WAIT2;
            zts_pkg::ST_WAIT2:
            begin
                if (done_a)
                begin
                    state_next = zts_pkg::ST_OUT;
                end
            end
            zts_pkg::ST_OUT:
            begin
                if (!stat_valid_reg || stat_ready)
                begin
                    state_next = zts_pkg::ST_IDLE;
                end
            end
            default: state_next = zts_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // fsm outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_ready = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        mem_ctl   = '0;
        case (state_reg)
            zts_pkg::ST_IDLE:
            begin
                cmd_ready       = 1'b1;
                mem_ctl.rd_en   = cmd_valid;
                mem_ctl.rd_addr = cmd.zone[zts_pkg::ZONE_IDX_W-1:0];
            end
            zts_pkg::ST_UPDATE:
            begin
                mem_ctl.wr_addr   = cmd_reg.zone[zts_pkg::ZONE_IDX_W-1:0];
                mem_ctl.wr_en     = zone_ok && (cmd_reg.opcode inside
                                    {zts_pkg::OP_START, zts_pkg::OP_END});
                mem_ctl.clear_all = cmd_reg.opcode == zts_pkg::OP_CLEAR;
            end
            zts_pkg::ST_KICK1, zts_pkg::ST_KICK2:
            begin
                div_start = 1'b1;
            end
            zts_pkg::ST_OUT:
            begin
                load_out = !stat_valid_reg || stat_ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign accept = cmd_valid && cmd_ready;

    // ------------------------------------------------------------------
    // read-modify-write of the addressed zone
    // ------------------------------------------------------------------
    zts_stat_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .wr_data (upd),
        .rd_data (mem_rd)
    );

    assign zone_ok = int'(cmd_reg.zone) < zts_pkg::NUM_ZONES;
    assign elapsed = cmd_reg.now_cycles - mem_rd.start_stamp;

    always_comb
    begin
        upd = mem_rd;
        case (cmd_reg.opcode)
            zts_pkg::OP_START:
            begin
                upd.start_stamp = cmd_reg.now_cycles;
            end
            zts_pkg::OP_END:
            begin
                if (elapsed < mem_rd.min_elapsed)
                begin
                    upd.min_elapsed = elapsed;
                end
                if (elapsed > mem_rd.max_elapsed)
                begin
                    upd.max_elapsed = elapsed;
                end
                upd.total_elapsed = mem_rd.total_elapsed + {32'd0, elapsed};
                upd.samples       = mem_rd.samples + 32'd1;
            end
            zts_pkg::OP_CLEAR:
            begin
                upd = zts_pkg::ENTRY_RESET;
            end
            default:
            begin
                upd = mem_rd;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // dividers: a does the average, b does min then max
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == zts_pkg::ST_KICK1)
        begin
            // high half below samples keeps the quotient within 32 bits
            req_a.dividend = work_reg.total_elapsed[31:0];
            req_a.divisor  = work_reg.samples;
            req_a.rem_init = work_reg.total_elapsed[63:32];
            req_b.dividend = work_reg.min_elapsed;
        end
        else
        begin
            req_a.dividend = sat_reg ? 32'hFFFF_FFFF : quo_a;
            req_a.divisor  = cpu_div;
            req_a.rem_init = 32'd0;
            req_b.dividend = work_reg.max_elapsed;
        end
        req_b.divisor  = cpu_div;
        req_b.rem_init = 32'd0;
    end

    zts_div u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (req_a),
        .done     (done_a),
        .quotient (quo_a)
    );

    zts_div u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (req_b),
        .done     (done_b),
        .quotient (quo_b)
    );

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next     = accept ? cmd : cmd_reg;
        work_next    = work_reg;
        zone_ok_next = zone_ok_reg;
        sat_next     = sat_reg;
        min_q_next   = min_q_reg;
        if (state_reg == zts_pkg::ST_UPDATE)
        begin
            work_next    = upd;
            zone_ok_next = zone_ok;
        end
        if (state_reg == zts_pkg::ST_KICK1)
        begin
            // average quotient would not fit in 32 bits
            sat_next = work_reg.total_elapsed[63:32] >= work_reg.samples;
        end
        if (state_reg == zts_pkg::ST_KICK2)
        begin
            min_q_next = quo_b;
        end
    end

    // result fields, zeroed for an unset minimum, no samples or a bad zone
    always_comb
    begin
        stat_next = stat_reg;
        if (load_out)
        begin
            stat_next = '0;
            if (zone_ok_reg)
            begin
                stat_next.avg_us       = (work_reg.samples != 32'd0) ? quo_a : 32'd0;
                stat_next.min_us       = (work_reg.min_elapsed != zts_pkg::MIN_UNSET)
                                         ? min_q_reg : 32'd0;
                stat_next.max_us       = quo_b;
                stat_next.sample_count = work_reg.samples;
            end
        end
        stat_valid_next = load_out ? 1'b1 : (stat_ready ? 1'b0 : stat_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= zts_pkg::ST_IDLE;
            cpu_reg        <= zts_pkg::CPU_RESET;
            stat_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cpu_reg        <= cpu_next;
            stat_valid_reg <= stat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        work_reg    <= work_next;
        zone_ok_reg <= zone_ok_next;
        sat_reg     <= sat_next;
        min_q_reg   <= min_q_next;
        stat_reg    <= stat_next;
    end

    assign stat_valid = stat_valid_reg;
    assign stat       = stat_reg;

`ifndef ASSERT_OFF
    // both dividers run the same number of steps
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_a == done_b)
        else $error("dividers out of step");

    // an accepted item goes straight to the update cycle
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> state_reg == zts_pkg::ST_UPDATE)
        else $error("accepted item not updated");

    // memory is written only in the update cycle
    a_wr_update: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en || mem_ctl.clear_all) |-> state_reg == zts_pkg::ST_UPDATE)
        else $error("memory write outside update");

    // a new result only follows the output state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat_valid) |-> $past(state_reg == zts_pkg::ST_OUT))
        else $error("result without output state");
`endif

endmodule
